// ===== hdl/rftr_pkg.sv =====
package rftr_pkg;

    localparam int FINGER_COUNT_DEF = 128;
    localparam int HASH_W           = 128;
    localparam int WORD_W           = 64;
    localparam int ID_W             = 16;
    localparam int CMD_W            = 3;
    localparam int FIDX_W           = 7;
    localparam int OUTCOME_W        = 2;
    localparam int CFG_IDX_W        = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP     = 3'd0,
        CMD_WR_FINGER  = 3'd1,
        CMD_SUCC_CAND  = 3'd2,
        CMD_NOTIFY     = 3'd3,
        CMD_PRED_DEAD  = 3'd4
    } cmd_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_SELF      = 2'd0,
        OUT_SUCC      = 2'd1,
        OUT_FORWARD   = 2'd2,
        OUT_NOT_FOUND = 2'd3
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_HASH_HI = 2'd0,
        CFG_OWN_HASH_LO = 2'd1,
        CFG_OWN_NODE_ID = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [ID_W-1:0]   id;
    } finger_entry_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    // Plain interval keeps its low end; a wrapped interval drops both ends.
    function automatic logic ring_in(input logic [HASH_W-1:0] lo_end,
                                     input logic [HASH_W-1:0] hi_end,
                                     input logic [HASH_W-1:0] x);
        logic hit;
        if (lo_end <= hi_end) begin
            hit = (lo_end <= x) && (x < hi_end);
        end else begin
            hit = ((lo_end < x) && (x > hi_end)) || ((lo_end > x) && (x < hi_end));
        end
        return hit;
    endfunction

endpackage

// ===== hdl/ring_finger_table_route_core.sv =====
// Lookup: EXEC checks for a self hit, SUCC for a successor hit, then LOAD and WALK
// compare finger i against i+1 until a hit, an empty finger or the last one ends it.
// The finger walk reads one table entry per cycle from the single read port.
// Other commands finish in EXEC; the next item is taken once the sequencer is idle.
// Reset (synchronous, active low) clears the state, config, neighbour and output-valid
// registers and the finger valid bits at once.
module ring_finger_table_route_core #(
    parameter int FINGER_COUNT = rftr_pkg::FINGER_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [rftr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rftr_pkg::WORD_W-1:0]        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [rftr_pkg::CMD_W-1:0]         s_command,
    input  logic [rftr_pkg::WORD_W-1:0]        s_key_high,
    input  logic [rftr_pkg::WORD_W-1:0]        s_key_low,
    input  logic [rftr_pkg::ID_W-1:0]          s_node_id,
    input  logic [rftr_pkg::FIDX_W-1:0]        s_finger_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rftr_pkg::OUTCOME_W-1:0]     m_outcome,
    output logic [rftr_pkg::ID_W-1:0]          m_target_id
);

    localparam int IDX_W = $clog2(FINGER_COUNT);
    localparam int CMP_W = ((IDX_W > rftr_pkg::FIDX_W) ? IDX_W : rftr_pkg::FIDX_W) + 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_SUCC = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_WALK = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [rftr_pkg::WORD_W-1:0] own_hi_reg, own_lo_reg;
    logic [rftr_pkg::ID_W-1:0]   own_id_reg;

    logic [rftr_pkg::HASH_W-1:0] succ_pos_reg, pred_hash_reg;
    logic [rftr_pkg::ID_W-1:0]   succ_id_reg, pred_id_reg;

    logic [rftr_pkg::CMD_W-1:0]  cmd_reg;
    logic [rftr_pkg::HASH_W-1:0] key_reg;
    logic [rftr_pkg::ID_W-1:0]   nid_reg;
    logic [rftr_pkg::FIDX_W-1:0] fidx_reg;

    rftr_pkg::finger_entry_t     cur_reg;
    logic [IDX_W-1:0]            walk_reg;

    logic [rftr_pkg::OUTCOME_W-1:0] res_outcome_reg;
    logic [rftr_pkg::ID_W-1:0]      res_id_reg;

    logic                           m_valid_reg;
    logic [rftr_pkg::OUTCOME_W-1:0] m_outcome_reg;
    logic [rftr_pkg::ID_W-1:0]      m_target_reg;

    rftr_pkg::mem_ctrl_t     mem_ctrl;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic [IDX_W-1:0]        mem_wr_addr;
    rftr_pkg::finger_entry_t mem_wr_data;
    rftr_pkg::finger_entry_t mem_rd_data;

    logic [rftr_pkg::HASH_W-1:0] own_hash;
    logic [rftr_pkg::HASH_W-1:0] next_hash;
    logic [CMP_W-1:0]            fidx_ext;
    logic [IDX_W:0]              walk_plus2;
    logic                        walk_last;
    logic                        pred_hit, succ_hit, finger_hit;
    logic                        succ_take, pred_take;
    logic                        s_xfer, out_free;

    assign own_hash   = {own_hi_reg, own_lo_reg};
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign fidx_ext   = CMP_W'(fidx_reg);
    assign walk_plus2 = {1'b0, walk_reg} + (IDX_W+1)'(2);
    assign walk_last  = (walk_reg == IDX_W'(FINGER_COUNT - 1));
    assign next_hash  = walk_last ? own_hash : mem_rd_data.hash;

    assign pred_hit   = (pred_id_reg != '0) && rftr_pkg::ring_in(pred_hash_reg, own_hash, key_reg);
    assign succ_hit   = (succ_id_reg != '0) && rftr_pkg::ring_in(own_hash, succ_pos_reg, key_reg);
    assign finger_hit = rftr_pkg::ring_in(cur_reg.hash, next_hash, key_reg);

    assign succ_take = (nid_reg != '0) && ((succ_id_reg == '0) ||
                       ((key_reg != own_hash) &&
                        rftr_pkg::ring_in(own_hash, succ_pos_reg, key_reg)));
    assign pred_take = (nid_reg != '0) && ((pred_id_reg == '0) ||
                       ((key_reg != pred_hash_reg) &&
                        rftr_pkg::ring_in(pred_hash_reg, own_hash, key_reg)));

    assign mem_wr_addr      = fidx_ext[IDX_W-1:0];
    assign mem_wr_data.hash = key_reg;
    assign mem_wr_data.id   = nid_reg;

    always_comb begin
        mem_ctrl.wr_en = (state_reg == ST_EXEC) && (cmd_reg == rftr_pkg::CMD_WR_FINGER)
                         && (fidx_ext < CMP_W'(FINGER_COUNT));
        mem_ctrl.rd_en = 1'b0;
        mem_rd_addr    = '0;
        case (state_reg)
            ST_SUCC: begin
                mem_ctrl.rd_en = 1'b1;
            end
            ST_LOAD: begin
                mem_ctrl.rd_en = 1'b1;
                mem_rd_addr    = IDX_W'(1);
            end
            ST_WALK: begin
                // prefetch finger i+2 while finger i is compared against i+1
                mem_ctrl.rd_en = (walk_plus2 < (IDX_W+1)'(FINGER_COUNT));
                mem_rd_addr    = walk_plus2[IDX_W-1:0];
            end
            default: begin
                mem_ctrl.rd_en = 1'b0;
            end
        endcase
    end

    rftr_finger_mem #(
        .FINGER_COUNT(FINGER_COUNT)
    ) u_finger_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mem_ctrl),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd_reg == rftr_pkg::CMD_LOOKUP) begin
                    state_next = pred_hit ? ST_DONE : ST_SUCC;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUCC: begin
                state_next = succ_hit ? ST_DONE : ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if ((cur_reg.id == '0) || finger_hit || walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_hi_reg <= '0;
            own_lo_reg <= '0;
            own_id_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                rftr_pkg::CFG_OWN_HASH_HI: own_hi_reg <= cfg_data;
                rftr_pkg::CFG_OWN_HASH_LO: own_lo_reg <= cfg_data;
                rftr_pkg::CFG_OWN_NODE_ID: own_id_reg <= cfg_data[rftr_pkg::ID_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            succ_pos_reg  <= '0;
            succ_id_reg   <= '0;
            pred_hash_reg <= '0;
            pred_id_reg   <= '0;
        end else if (state_reg == ST_EXEC) begin
            case (cmd_reg)
                rftr_pkg::CMD_SUCC_CAND: begin
                    if (succ_take) begin
                        succ_pos_reg <= key_reg;
                        succ_id_reg  <= nid_reg;
                    end
                end
                rftr_pkg::CMD_NOTIFY: begin
                    if (pred_take) begin
                        pred_hash_reg <= key_reg;
                        pred_id_reg   <= nid_reg;
                    end
                end
                rftr_pkg::CMD_PRED_DEAD: begin
                    // keep the hash, forget the node
                    pred_id_reg <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            cmd_reg  <= s_command;
            key_reg  <= {s_key_high, s_key_low};
            nid_reg  <= s_node_id;
            fidx_reg <= s_finger_index;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_EXEC: begin
                res_outcome_reg <= rftr_pkg::OUT_SELF;
                res_id_reg      <= own_id_reg;
            end
            ST_SUCC: begin
                res_outcome_reg <= rftr_pkg::OUT_SUCC;
                res_id_reg      <= succ_id_reg;
            end
            ST_LOAD: begin
                cur_reg  <= mem_rd_data;
                walk_reg <= '0;
            end
            ST_WALK: begin
                if (cur_reg.id == '0) begin
                    res_outcome_reg <= rftr_pkg::OUT_FORWARD;
                    res_id_reg      <= succ_id_reg;
                end else if (finger_hit) begin
                    res_outcome_reg <= rftr_pkg::OUT_FORWARD;
                    res_id_reg      <= cur_reg.id;
                end else if (walk_last) begin
                    res_outcome_reg <= rftr_pkg::OUT_NOT_FOUND;
                    res_id_reg      <= '0;
                end else begin
                    cur_reg  <= mem_rd_data;
                    walk_reg <= walk_reg + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            m_outcome_reg <= res_outcome_reg;
            m_target_reg  <= res_id_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_outcome   = m_outcome_reg;
    assign m_target_id = m_target_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome == rftr_pkg::OUT_NOT_FOUND) |-> (m_target_id == '0))
        else $error("not-found result carries a target");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> ({1'b0, walk_reg} < (IDX_W+1)'(FINGER_COUNT)))
        else $error("finger walk past table end");

    a_done_no_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !mem_ctrl.rd_en && !mem_ctrl.wr_en)
        else $error("finger table access while result is pending");

endmodule

// ===== hdl/rftr_finger_mem.sv =====
module rftr_finger_mem #(
    parameter int FINGER_COUNT = rftr_pkg::FINGER_COUNT_DEF,
    localparam int IDX_W = $clog2(FINGER_COUNT)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rftr_pkg::mem_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]        wr_addr,
    input  rftr_pkg::finger_entry_t wr_data,
    input  logic [IDX_W-1:0]        rd_addr,
    output rftr_pkg::finger_entry_t rd_data
);

    rftr_pkg::finger_entry_t mem [FINGER_COUNT];
    logic [FINGER_COUNT-1:0] valid_reg;
    rftr_pkg::finger_entry_t rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // an entry never written reads as the cleared value
    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
